/* sv/xcpf_pkg.sv */
// shared types, constants and helpers for the xor checked packet framer
`default_nettype none

package xcpf_pkg;

	// sizing limits
	localparam int MAX_PREAMBLE    = 8;
	localparam int MAX_SEGMENTS    = 8;
	localparam int MAX_SEGMENT_LEN = 64;
	localparam int LENGTH_BITS     = 20;

	// register field widths
	localparam int SEG_LEN_W = 7;
	localparam int SEG_CNT_W = 4;
	localparam int PRE_LEN_W = 4;
	localparam int PRE_WORD_W = 64;

	// position counter widths
	localparam int PPOS_W = $clog2(MAX_PREAMBLE);
	localparam int SPOS_W = $clog2(MAX_SEGMENTS);
	localparam int BPOS_W = $clog2(MAX_SEGMENT_LEN);

	localparam logic [7:0] FULL_BYTE = 8'hFF;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_FILE_LENGTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LEN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_LEN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_WORD = 3'd4;

	typedef enum logic [3:0] {
		PH_PRE  = 4'b0001,
		PH_PAY  = 4'b0010,
		PH_CHK  = 4'b0100,
		PH_DONE = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [LENGTH_BITS-1:0] file_length;
		logic [SEG_LEN_W-1:0]   segment_len;
		logic [SEG_CNT_W-1:0]   segment_count;
		logic [PRE_LEN_W-1:0]   preamble_len;
		logic [PRE_WORD_W-1:0]  preamble_word;
	} cfg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       took_data;
		logic       in_header;
		logic       last;
		logic       error;
	} res_t;

	// clamp helpers for the live register values
	function automatic logic [SEG_LEN_W-1:0] eff_seg_len(input logic [SEG_LEN_W-1:0] v);
		logic [SEG_LEN_W-1:0] r;
		r = v;
		if (v == '0)
			r = SEG_LEN_W'(1);
		else if (v > SEG_LEN_W'(MAX_SEGMENT_LEN))
			r = SEG_LEN_W'(MAX_SEGMENT_LEN);
		return r;
	endfunction

	function automatic logic [SEG_CNT_W-1:0] eff_seg_count(input logic [SEG_CNT_W-1:0] v);
		logic [SEG_CNT_W-1:0] r;
		r = v;
		if (v == '0)
			r = SEG_CNT_W'(1);
		else if (v > SEG_CNT_W'(MAX_SEGMENTS))
			r = SEG_CNT_W'(MAX_SEGMENTS);
		return r;
	endfunction

	function automatic logic [PRE_LEN_W-1:0] eff_preamble(input logic [PRE_LEN_W-1:0] v);
		logic [PRE_LEN_W-1:0] r;
		r = v;
		if (v > PRE_LEN_W'(MAX_PREAMBLE))
			r = PRE_LEN_W'(MAX_PREAMBLE);
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/xcpf_engine.sv */
// framing state, checksum store and the per-byte next-state logic
`default_nettype none

module xcpf_engine
	import xcpf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] data_byte,
	input  wire cfg_t       cfg,
	output res_t            res
);

	logic                   started_q;
	phase_t                 phase_q;
	logic                   hdr_q;
	logic [PPOS_W-1:0]      pp_q;
	logic [SPOS_W-1:0]      sp_q;
	logic [BPOS_W-1:0]      bp_q;
	logic [7:0]             xor_q;
	logic [LENGTH_BITS-1:0] hrem_q;
	logic [LENGTH_BITS-1:0] file_q;
	logic [7:0]             store_q [MAX_SEGMENTS];

	logic                   n_started;
	phase_t                 n_phase;
	logic                   n_hdr;
	logic [PPOS_W-1:0]      n_pp;
	logic [SPOS_W-1:0]      n_sp;
	logic [BPOS_W-1:0]      n_bp;
	logic [7:0]             n_xor;
	logic [LENGTH_BITS-1:0] n_hrem;
	logic [LENGTH_BITS-1:0] n_file;

	logic                   wr_en;
	logic [SPOS_W-1:0]      wr_addr;
	logic [7:0]             wr_data;

	logic [PRE_LEN_W-1:0]   eff_pre;
	logic [SEG_LEN_W-1:0]   eff_sl;
	logic [SEG_CNT_W-1:0]   eff_sc;
	logic [PRE_LEN_W-1:0]   pp1;
	logic [SEG_LEN_W-1:0]   bp1;
	logic [SEG_CNT_W-1:0]   sp1;

	assign eff_pre = eff_preamble(cfg.preamble_len);
	assign eff_sl  = eff_seg_len(cfg.segment_len);
	assign eff_sc  = eff_seg_count(cfg.segment_count);

	always_comb begin
		res       = '0;
		n_started = started_q;
		n_phase   = phase_q;
		n_hdr     = hdr_q;
		n_pp      = pp_q;
		n_sp      = sp_q;
		n_bp      = bp_q;
		n_xor     = xor_q;
		n_hrem    = hrem_q;
		n_file    = file_q;
		wr_en     = 1'b0;
		wr_addr   = sp_q;
		wr_data   = '0;
		pp1       = '0;
		bp1       = '0;
		sp1       = '0;

		if (!started_q && cfg.file_length == '0) begin
			res.error = 1'b1;
		end else begin
			// latch the length on the first byte
			if (!started_q) begin
				n_started = 1'b1;
				n_phase   = PH_PRE;
				n_hdr     = 1'b1;
				n_pp      = '0;
				n_sp      = '0;
				n_bp      = '0;
				n_xor     = '0;
				n_hrem    = cfg.file_length;
				n_file    = cfg.file_length;
			end

			if (n_phase != PH_DONE) begin
				if (n_phase == PH_PRE && PRE_LEN_W'(n_pp) >= eff_pre) begin
					n_phase = PH_PAY;
					n_pp    = '0;
				end
				res.in_header = n_hdr;

				unique case (n_phase)
					PH_PRE: begin
						res.out_byte = cfg.preamble_word[{n_pp, 3'b000} +: 8];
						pp1 = PRE_LEN_W'(n_pp) + PRE_LEN_W'(1);
						if (pp1 >= eff_pre) begin
							n_phase = PH_PAY;
							n_pp    = '0;
						end else begin
							n_pp = pp1[PPOS_W-1:0];
						end
					end
					PH_PAY: begin
						if (n_hdr) begin
							// length as runs of 255 and any nonzero remainder byte
							if (n_hrem != '0) begin
								if (n_hrem >= LENGTH_BITS'(FULL_BYTE)) begin
									res.out_byte = FULL_BYTE;
									n_hrem = n_hrem - LENGTH_BITS'(FULL_BYTE);
								end else begin
									res.out_byte = n_hrem[7:0];
									n_hrem = '0;
								end
							end
						end else if (n_file != '0) begin
							res.out_byte  = data_byte;
							res.took_data = 1'b1;
							n_file = n_file - LENGTH_BITS'(1);
						end
						n_xor = n_xor ^ res.out_byte;
						bp1 = SEG_LEN_W'(n_bp) + SEG_LEN_W'(1);
						if (bp1 >= eff_sl) begin
							wr_en   = 1'b1;
							wr_addr = n_sp;
							wr_data = n_hdr ? ~n_xor : n_xor;
							n_xor   = '0;
							n_bp    = '0;
							sp1 = SEG_CNT_W'(n_sp) + SEG_CNT_W'(1);
							if (sp1 >= eff_sc) begin
								n_phase = PH_CHK;
								n_sp    = '0;
							end else begin
								n_sp = sp1[SPOS_W-1:0];
							end
						end else begin
							n_bp = bp1[BPOS_W-1:0];
						end
					end
					PH_CHK: begin
						res.out_byte = store_q[n_sp];
						sp1 = SEG_CNT_W'(n_sp) + SEG_CNT_W'(1);
						if (sp1 >= eff_sc) begin
							n_sp  = '0;
							n_bp  = '0;
							n_xor = '0;
							n_pp  = '0;
							if (n_hdr) begin
								if (n_hrem == '0)
									n_hdr = 1'b0;
								n_phase = PH_PRE;
							end else if (n_file != '0) begin
								n_phase = PH_PRE;
							end else begin
								n_phase  = PH_DONE;
								res.last = 1'b1;
							end
						end else begin
							n_sp = sp1[SPOS_W-1:0];
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			phase_q   <= PH_PRE;
			hdr_q     <= 1'b1;
			pp_q      <= '0;
			sp_q      <= '0;
			bp_q      <= '0;
			xor_q     <= '0;
			hrem_q    <= '0;
			file_q    <= '0;
		end else if (step) begin
			started_q <= n_started;
			phase_q   <= n_phase;
			hdr_q     <= n_hdr;
			pp_q      <= n_pp;
			sp_q      <= n_sp;
			bp_q      <= n_bp;
			xor_q     <= n_xor;
			hrem_q    <= n_hrem;
			file_q    <= n_file;
		end
	end

	// segment checksums, valid only once written
	always_ff @(posedge clk) begin
		if (step && wr_en)
			store_q[wr_addr] <= wr_data;
	end

endmodule

`default_nettype wire

/* sv/xor_checked_packet_framer_core.sv */
// top level of the xor checked packet framer: ports, registers, skid and result stages
`default_nettype none

// Pull-driven transmit framer. Every transfer on the input stream asks for one
// stream byte and returns exactly one result transfer. The first request latches
// file_length; header packets then carry the length as 255-valued bytes and any
// nonzero remainder byte, and data packets carry the file bytes. Each packet is
// the preamble, segment_count segments of segment_len bytes (zero padded once
// the file runs out), then one xor checksum per segment, inverted in header
// packets. The offered data byte is consumed only when took_data comes back set;
// otherwise the source must offer the same byte again. A zero file_length gives
// a result with error set and nothing else. After the byte flagged last, every
// result is all zero until reset. The block takes one request per clock cycle
// while the result stream is not stalled; a request passes the input register,
// then the result register. The rate is set by the combinational update of the
// framing counters, length subtract and running xor. The user writes configuration
// only while the block is idle (not enforced); the write channel is always ready.
module xor_checked_packet_framer_core
	import xcpf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// request stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,   // [7:0] data_byte
	// result stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [15:0]                m_tdata,   // [7:0] out_byte, [8] took_data, [9] error
	output logic                       m_tuser,   // [0] in_header
	output logic                       m_tlast,   // last byte of the transmission
	// configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [PRE_WORD_W-1:0] cfg_data
);

	cfg_t       cfg_q;
	logic       v_s1;
	logic [7:0] data_s1;
	logic       v_s2;
	res_t       res_s2;
	res_t       eng_res;
	logic       adv;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.file_length   <= LENGTH_BITS'(1);
			cfg_q.segment_len   <= SEG_LEN_W'(8);
			cfg_q.segment_count <= SEG_CNT_W'(1);
			cfg_q.preamble_len  <= '0;
			cfg_q.preamble_word <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FILE_LENGTH:   cfg_q.file_length   <= cfg_data[LENGTH_BITS-1:0];
				REG_SEGMENT_LEN:   cfg_q.segment_len   <= cfg_data[SEG_LEN_W-1:0];
				REG_SEGMENT_COUNT: cfg_q.segment_count <= cfg_data[SEG_CNT_W-1:0];
				REG_PREAMBLE_LEN:  cfg_q.preamble_len  <= cfg_data[PRE_LEN_W-1:0];
				REG_PREAMBLE_WORD: cfg_q.preamble_word <= cfg_data;
				default: ;
			endcase
		end
	end

	// the held request moves into the engine when the result stage has room
	assign adv      = v_s1 && (!v_s2 || m_tready);
	assign s_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (s_tready)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			data_s1 <= s_tdata;
	end

	xcpf_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.data_byte (data_s1),
		.cfg       (cfg_q),
		.res       (eng_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= 1'b1;
		else if (m_tready)
			v_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= eng_res;
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = {6'b0, res_s2.error, res_s2.took_data, res_s2.out_byte};
	assign m_tuser  = res_s2.in_header;
	assign m_tlast  = res_s2.last;

	// a held request with a blocked result stage stays put
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && !m_tready |=> v_s1 && $stable(data_s1))
		else $error("held request lost while result stage blocked");

	// a result only shows up after the engine stepped
	a_s2_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s2) |-> $past(adv))
		else $error("result valid without an engine step");

	// file bytes are never taken inside header packets or on an error
	a_took_clean: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eng_res.took_data |-> !eng_res.in_header && !eng_res.error)
		else $error("data taken in header packet or on error");

	// an error result carries nothing else
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eng_res.error |-> eng_res.out_byte == 8'h00 && !eng_res.last)
		else $error("error result with payload");

endmodule

`default_nettype wire
